// File: hdl/bsp_pkg.sv
// Shared types and constants of the bit stream packer.
package bsp_pkg;

  localparam int unsigned FIELD_W = 72;
  localparam int unsigned SH_W    = 80;

  localparam logic [2:0] KIND_BITS  = 3'd0;
  localparam logic [2:0] KIND_LE    = 3'd1;
  localparam logic [2:0] KIND_VI_LE = 3'd2;
  localparam logic [2:0] KIND_VI_BE = 3'd3;
  localparam logic [2:0] KIND_FLUSH = 3'd4;

  localparam logic [7:0] VARINT_TWO   = 8'hFD;
  localparam logic [7:0] VARINT_FOUR  = 8'hFE;
  localparam logic [7:0] VARINT_EIGHT = 8'hFF;

  typedef struct packed {
    logic [FIELD_W-1:0] field;
    logic [6:0]         nbits;
    logic               flush;
  } bsp_enc_t;

endpackage

// File: hdl/bsp_encode.sv
// Item encoder: turns one item into a left-aligned bit field and its length.
module bsp_encode import bsp_pkg::*; (
  input  logic [2:0]  kind,
  input  logic [63:0] value,
  input  logic [6:0]  bit_count,
  input  logic [3:0]  byte_count,
  output bsp_enc_t    enc
);

  logic [63:0]        rev;
  logic [6:0]         nbit0;
  logic [3:0]         nbyte1;
  logic [3:0]         vnb;
  logic [7:0]         prefix;
  logic [FIELD_W-1:0] raw;
  logic [6:0]         nbits;
  logic               flush;
  logic [FIELD_W-1:0] mask;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      rev[63-8*j -: 8] = value[8*j +: 8];
    end
  end

  always_comb begin
    nbit0  = (bit_count > 7'd64) ? 7'd64 : bit_count;
    nbyte1 = (byte_count > 4'd8) ? 4'd8 : byte_count;
    if (value <= 64'hFFFF) begin
      prefix = VARINT_TWO;
      vnb    = 4'd2;
    end else if (value <= 64'hFFFF_FFFF) begin
      prefix = VARINT_FOUR;
      vnb    = 4'd4;
    end else begin
      prefix = VARINT_EIGHT;
      vnb    = 4'd8;
    end
  end

  always_comb begin
    raw   = '0;
    nbits = '0;
    flush = 1'b0;
    unique case (kind)
      KIND_BITS: begin
        raw   = {value, 8'h00} << (7'd64 - nbit0);
        nbits = nbit0;
      end
      KIND_LE: begin
        raw   = {rev, 8'h00};
        nbits = {nbyte1, 3'b000};
      end
      KIND_VI_LE, KIND_VI_BE: begin
        if (value < 64'(VARINT_TWO)) begin
          raw   = {value[7:0], 64'h0};
          nbits = 7'd8;
        end else begin
          if (kind == KIND_VI_LE) begin
            raw = {prefix, rev};
          end else begin
            raw = {prefix, value << (7'd64 - {vnb, 3'b000})};
          end
          nbits = 7'd8 + {vnb, 3'b000};
        end
      end
      KIND_FLUSH: begin
        flush = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign mask = {FIELD_W{1'b1}} << (7'(FIELD_W) - nbits);
  assign enc  = {raw & mask, nbits, flush};

endmodule

// File: hdl/bsp_emit.sv
// Byte emitter: merges the partial byte with a field and shifts out whole bytes.
module bsp_emit import bsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       enc_valid,
  input  bsp_enc_t   enc,
  output logic       load,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [7:0]      partial_r;
  logic [2:0]      fill_r;
  logic [SH_W-1:0] sh_r;
  logic [3:0]      cnt_r;
  logic            out_valid_r;
  logic [7:0]      out_byte_r;
  logic            out_last_r;

  logic            move;
  logic [SH_W-1:0] combined;
  logic [6:0]      total;
  logic [3:0]      nbytes;
  logic [6:0]      sel;
  logic [7:0]      partial_nxt;

  assign move = (cnt_r != 4'd0) && (!out_valid_r || !out_stall);
  assign load = enc_valid && ((cnt_r == 4'd0) || ((cnt_r == 4'd1) && move));

  always_comb begin
    combined = {partial_r, {FIELD_W{1'b0}}} | ({enc.field, 8'h00} >> fill_r);
    if (enc.flush && (fill_r != 3'd0)) begin
      total = 7'd8;
    end else begin
      total = {4'b0000, fill_r} + enc.nbits;
    end
    nbytes      = total[6:3];
    sel         = 7'(SH_W - 1) - {nbytes, 3'b000};
    partial_nxt = combined[sel -: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r   <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        partial_r <= partial_nxt;
        fill_r    <= total[2:0];
        cnt_r     <= nbytes;
      end else if (move) begin
        cnt_r <= cnt_r - 4'd1;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh_r <= combined;
    end else if (move) begin
      sh_r <= sh_r << 8;
    end
    if (move) begin
      out_byte_r <= sh_r[SH_W-1 -: 8];
      out_last_r <= (cnt_r == 4'd1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// File: hdl/bit_stream_packer_varint.sv
// Top level of the bit stream packer with compact-size varints.
// Path: an accepted item is registered at the input, loaded into the byte shifter
// and shifted into the output byte register. Throughput: one byte per cycle while
// out_stall is low; an item completes at most nine bytes (an eight-byte varint).
// Reset clears the partial byte, its fill count and all valid flags.
module bit_stream_packer_varint import bsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [63:0] in_value,
  input  logic [6:0]  in_bit_count,
  input  logic [3:0]  in_byte_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  logic        hold_r;
  logic [2:0]  kind_r;
  logic [63:0] value_r;
  logic [6:0]  bit_count_r;
  logic [3:0]  byte_count_r;
  logic        load;
  bsp_enc_t    enc;

  assign in_stall = hold_r && !load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_r <= 1'b1;
    end else if (load) begin
      hold_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_r       <= in_kind;
      value_r      <= in_value;
      bit_count_r  <= in_bit_count;
      byte_count_r <= in_byte_count;
    end
  end

  bsp_encode u_encode (
    .kind       (kind_r),
    .value      (value_r),
    .bit_count  (bit_count_r),
    .byte_count (byte_count_r),
    .enc        (enc)
  );

  bsp_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .enc_valid (hold_r),
    .enc       (enc),
    .load      (load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the bit stream packer with compact-size varints.
`timescale 1ns / 1ps

module tb_top;
  import bsp_pkg::*;

  localparam logic [2:0] KIND_LAST_SPARE = 3'd7;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_last;
  } packed_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = '0;
  logic [63:0] in_value = '0;
  logic [6:0]  in_bit_count = '0;
  logic [3:0]  in_byte_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;

  packed_byte_t expected_bytes[$];
  logic [7:0]   item_bytes[$];
  logic [7:0]   pk_partial = '0;
  logic [2:0]   pk_fill = '0;

  int mismatch_count = 0;
  int send_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_cycles = 0;
  int hold_count = 0;

  bit_stream_packer_varint DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_value      (in_value),
    .in_bit_count  (in_bit_count),
    .in_byte_count (in_byte_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last      (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void pack_bit(input logic b);
    if (b) pk_partial[3'd7 - pk_fill] = 1'b1;
    if (pk_fill == 3'd7) begin
      item_bytes.push_back(pk_partial);
      pk_partial = '0;
      pk_fill = '0;
    end else begin
      pk_fill = pk_fill + 3'd1;
    end
  endfunction

  function automatic void pack_byte(input logic [7:0] v);
    for (int i = 7; i >= 0; i--) pack_bit(v[i]);
  endfunction

  function automatic void pack_varint(input logic [63:0] v, input logic big_endian);
    int n;
    if (v < 64'(VARINT_TWO)) begin
      pack_byte(v[7:0]);
      return;
    end
    if (v <= 64'hFFFF) begin
      pack_byte(VARINT_TWO);
      n = 2;
    end else if (v <= 64'hFFFF_FFFF) begin
      pack_byte(VARINT_FOUR);
      n = 4;
    end else begin
      pack_byte(VARINT_EIGHT);
      n = 8;
    end
    for (int i = 0; i < n; i++) begin
      if (big_endian) pack_byte(v[8*(n-1-i) +: 8]);
      else pack_byte(v[8*i +: 8]);
    end
  endfunction

  // Advance the packer state by one item and queue the bytes it completes.
  function automatic void pack_item_bytes(input logic [2:0] kind, input logic [63:0] value,
                                          input logic [6:0] nbits, input logic [3:0] nbytes);
    int n;
    item_bytes.delete();
    case (kind)
      KIND_BITS: begin
        n = (nbits > 7'd64) ? 64 : int'(nbits);
        for (int i = n; i > 0; i--) pack_bit(value[i-1]);
      end
      KIND_LE: begin
        n = (nbytes > 4'd8) ? 8 : int'(nbytes);
        for (int i = 0; i < n; i++) pack_byte(value[8*i +: 8]);
      end
      KIND_VI_LE: pack_varint(value, 1'b0);
      KIND_VI_BE: pack_varint(value, 1'b1);
      KIND_FLUSH: begin
        if (pk_fill != 3'd0) begin
          item_bytes.push_back(pk_partial);
          pk_partial = '0;
          pk_fill = '0;
        end
      end
      default: ;
    endcase
    for (int k = 0; k < item_bytes.size(); k++)
      expected_bytes.push_back('{item_bytes[k], k == item_bytes.size() - 1});
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_item(input logic [2:0] kind, input logic [63:0] value,
                           input logic [6:0] nbits, input logic [3:0] nbytes);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_value      <= value;
    in_bit_count  <= nbits;
    in_byte_count <= nbytes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pack_item_bytes(kind, value, nbits, nbytes);
  endtask

  task automatic send_random_item(output bit useful);
    logic [2:0]  kind;
    logic [63:0] value;
    logic [6:0]  nbits;
    logic [3:0]  nbytes;
    int r;
    r = $urandom_range(99);
    if (r < 40) kind = KIND_BITS;
    else if (r < 55) kind = KIND_LE;
    else if (r < 70) kind = KIND_VI_LE;
    else if (r < 85) kind = KIND_VI_BE;
    else if (r < 95) kind = KIND_FLUSH;
    else kind = KIND_FLUSH + 3'($urandom_range(1, KIND_LAST_SPARE - KIND_FLUSH));
    value = {$urandom, $urandom};
    if ($urandom_range(1)) value = value >> $urandom_range(63);
    nbits = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 64));
    nbytes = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
    useful = (kind <= KIND_FLUSH);
    send_item(kind, value, nbits, nbytes);
  endtask

  task automatic test_bit_fields();
    send_item(KIND_BITS, 64'h1, 7'd1, 4'd0);
    send_item(KIND_BITS, 64'h55, 7'd7, 4'd0);
    send_item(KIND_BITS, '1, 7'd64, 4'd15);
    send_item(KIND_BITS, 64'h3, 7'd3, 4'd0);
    send_item(KIND_BITS, '1, 7'd0, 4'd8);
    send_item(KIND_BITS, 64'hA5A5_5A5A_C3C3_3C3C, 7'd65, 4'd0);
    send_item(KIND_BITS, 64'h0123_4567_89AB_CDEF, 7'd127, 4'd0);
    send_item(KIND_BITS, '0, 7'd5, 4'd0);
  endtask

  task automatic test_byte_ints();
    send_item(KIND_BITS, 64'h2, 7'd2, 4'd0);
    send_item(KIND_LE, '1, 7'd0, 4'd0);
    send_item(KIND_LE, 64'h81, 7'd0, 4'd1);
    send_item(KIND_LE, 64'hFEDC_BA98_7654_3210, 7'd127, 4'd8);
    send_item(KIND_LE, '1, 7'd0, 4'd15);
  endtask

  task automatic test_varints();
    send_item(KIND_VI_LE, '0, 7'd0, 4'd0);
    send_item(KIND_VI_LE, 64'hFC, 7'd0, 4'd0);
    send_item(KIND_VI_LE, 64'(VARINT_TWO), 7'd0, 4'd0);
    send_item(KIND_VI_LE, 64'hFFFF, 7'd0, 4'd0);
    send_item(KIND_VI_BE, 64'h1_0000, 7'd0, 4'd0);
    send_item(KIND_VI_BE, 64'hFFFF_FFFF, 7'd0, 4'd0);
    send_item(KIND_VI_BE, 64'h1_0000_0000, 7'd0, 4'd0);
    send_item(KIND_VI_BE, '1, 7'd0, 4'd0);
  endtask

  task automatic test_flush_and_spare_kinds();
    send_item(KIND_BITS, 64'h5, 7'd3, 4'd0);
    for (int k = KIND_FLUSH + 1; k <= KIND_LAST_SPARE; k++)
      send_item(3'(k), '1, 7'd64, 4'd8);
    send_item(KIND_FLUSH, '0, 7'd0, 4'd0);
    send_item(KIND_FLUSH, '1, 7'd127, 4'd15);
  endtask

  task automatic test_random_items(input int count, input int send_pct, input int stall_pct);
    int sent;
    bit useful;
    sent = 0;
    send_idle_pct = send_pct;
    out_stall_pct = stall_pct;
    while (sent < count) begin
      send_random_item(useful);
      if (useful) sent++;
    end
  endtask

  // Hold the output off long enough for the block to back up into its input.
  task automatic test_backpressure();
    bit useful;
    send_idle_pct = 0;
    out_stall_pct = 0;
    hold_cycles = 250;
    for (int i = 0; i < 40; i++) send_random_item(useful);
  endtask

  always @(posedge clk) begin
    if (hold_count < hold_cycles) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin : check_bytes
    packed_byte_t exp_byte;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %b", out_byte, out_last));
      end else begin
        exp_byte = expected_bytes.pop_front();
        if (out_byte !== exp_byte.byte_val)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, exp_byte.byte_val));
        if (out_last !== exp_byte.is_last)
          report_mismatch($sformatf("out_last %b, expected %b on byte %02h",
                                    out_last, exp_byte.is_last, exp_byte.byte_val));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_bit_fields();
    test_byte_ints();
    test_varints();
    test_flush_and_spare_kinds();
    test_random_items(80, 0, 0);
    test_random_items(80, 47, 0);
    test_random_items(80, 0, 47);
    test_random_items(80, 19, 19);
    test_backpressure();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("bit_stream_packer_varint regression: pass");
    end else begin
      $display("bit_stream_packer_varint regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("bit_stream_packer_varint regression: fail");
    $finish;
  end

endmodule
